>>> rtl/cbp_pkg.sv
`timescale 1ns / 1ps

package cbp_pkg;

    // default widths
    localparam int COORD_BITS_DEF  = 16;
    localparam int T_FRAC_BITS_DEF = 12;

    // pipeline depth from input word to output register
    localparam int STAGES = 6;

    // register indexes on the configuration port
    localparam logic [1:0] REG_POINT0 = 2'd0;
    localparam logic [1:0] REG_POINT1 = 2'd1;
    localparam logic [1:0] REG_POINT2 = 2'd2;
    localparam logic [1:0] REG_POINT3 = 2'd3;

    // control point coordinates after reset, signed Q8.8
    localparam logic signed [15:0] P0_X_RST = 16'shFB00;
    localparam logic signed [15:0] P0_Y_RST = 16'shFB00;
    localparam logic signed [15:0] P0_Z_RST = 16'sh0000;
    localparam logic signed [15:0] P1_X_RST = 16'sh0500;
    localparam logic signed [15:0] P1_Y_RST = 16'sh0100;
    localparam logic signed [15:0] P1_Z_RST = 16'sh0300;
    localparam logic signed [15:0] P2_X_RST = 16'shFB00;
    localparam logic signed [15:0] P2_Y_RST = 16'sh0500;
    localparam logic signed [15:0] P2_Z_RST = 16'sh0000;
    localparam logic signed [15:0] P3_X_RST = 16'sh0000;
    localparam logic signed [15:0] P3_Y_RST = 16'sh0000;
    localparam logic signed [15:0] P3_Z_RST = 16'sh0000;

endpackage

>>> rtl/cubic_bezier_point.sv
`timescale 1ns / 1ps

// Cubic Bezier point evaluator: each input word carries a curve parameter t
// (unsigned, one integer bit and T_FRAC_BITS fraction bits, values above 1.0
// clamp to 1.0) and produces one output word with the x, y and z of the curve
// at t, computed from the four control points in the configuration registers
// as the Bernstein blend, rounded to nearest with ties toward plus infinity.
// The block takes one word per cycle unless the output stalls, through the
// stages clamp, t^2/u^2/3tu products, the four weights, the twelve
// weight-by-coordinate products, a pair add and the final add with rounding.
// A stall on the output holds the whole pipeline, and the input stays ready
// whenever the output register is empty or being taken. The user must write
// control points only while no word is in flight; the block does not enforce it.

module cubic_bezier_point #(
    parameter int COORD_BITS  = cbp_pkg::COORD_BITS_DEF,
    parameter int T_FRAC_BITS = cbp_pkg::T_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [3*COORD_BITS-1:0]       i_cfg_data,
    // input stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [((T_FRAC_BITS+8)/8)*8-1:0] i_s_axis_tdata, // t_param
    // output stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [((3*COORD_BITS+7)/8)*8-1:0] o_m_axis_tdata  // pos_x, pos_y, pos_z
);

    localparam int C     = COORD_BITS;
    localparam int F     = T_FRAC_BITS;
    localparam int TW    = F + 1;            // t and u
    localparam int W2    = 2 * F + 1;        // second-order products
    localparam int WW    = 3 * F + 1;        // weights
    localparam int PW    = 3 * F + C + 1;    // weighted coordinates and sums
    localparam int OUT_W = ((3 * C + 7) / 8) * 8;
    localparam int NS    = cbp_pkg::STAGES;

    localparam logic [TW-1:0] T_ONE   = {1'b1, {F{1'b0}}};
    localparam logic [C-1:0]  C_SIGN  = {1'b1, {(C-1){1'b0}}};
    localparam logic [PW-1:0] HALF    = PW'(1) << (3 * F - 1);
    localparam logic [WW-1:0] W_TOTAL = {1'b1, {(3*F){1'b0}}};

    // reset words are the packed 48-bit defaults, cut or widened to the register
    localparam logic [3*C-1:0] P0_RST = (3*C)'({cbp_pkg::P0_X_RST, cbp_pkg::P0_Y_RST,
                                                cbp_pkg::P0_Z_RST});
    localparam logic [3*C-1:0] P1_RST = (3*C)'({cbp_pkg::P1_X_RST, cbp_pkg::P1_Y_RST,
                                                cbp_pkg::P1_Z_RST});
    localparam logic [3*C-1:0] P2_RST = (3*C)'({cbp_pkg::P2_X_RST, cbp_pkg::P2_Y_RST,
                                                cbp_pkg::P2_Z_RST});
    localparam logic [3*C-1:0] P3_RST = (3*C)'({cbp_pkg::P3_X_RST, cbp_pkg::P3_Y_RST,
                                                cbp_pkg::P3_Z_RST});

    // control points, x in the top coordinate
    logic [3*C-1:0] r_pt [4];

    // stage valid bits
    logic [NS-1:0]  r_vld;
    logic           adv;

    // stage 1: clamped t, u and 3u
    logic [TW-1:0]   r_t1, r_u1;
    logic [TW+1:0]   r_u3;
    logic [TW-1:0]   n_t1, n_u1;
    logic [TW+1:0]   n_u3;
    // stage 2: t^2, u^2, 3tu
    logic [TW-1:0]   r_t2, r_u2;
    logic [W2-1:0]   r_tt, r_uu, r_tu3;
    // stage 3: Bernstein weights
    logic [WW-1:0]   r_w [4];
    // stage 4: weighted biased coordinates, [coordinate][point]
    logic [PW-1:0]   r_p [3][4];
    logic [C-1:0]    q   [3][4];
    // stage 5: pair sums
    logic [PW-1:0]   r_s01 [3];
    logic [PW-1:0]   r_s23 [3];
    // stage 6: output word
    logic [3*C-1:0]  r_out;
    logic [3*C-1:0]  n_out;
    logic [PW-1:0]   tot [3];

    // pipeline moves when the output register is free or being taken
    assign adv             = !r_vld[NS-1] || i_m_axis_tready;
    assign o_s_axis_tready = adv;
    assign o_m_axis_tvalid = r_vld[NS-1];
    assign o_m_axis_tdata  = OUT_W'(r_out);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt[0] <= P0_RST;
            r_pt[1] <= P1_RST;
            r_pt[2] <= P2_RST;
            r_pt[3] <= P3_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cbp_pkg::REG_POINT0: r_pt[0] <= i_cfg_data;
                cbp_pkg::REG_POINT1: r_pt[1] <= i_cfg_data;
                cbp_pkg::REG_POINT2: r_pt[2] <= i_cfg_data;
                cbp_pkg::REG_POINT3: r_pt[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NS-2:0], i_s_axis_tvalid};
        end
    end

    // clamp t to one, form u and 3u
    always_comb begin
        n_t1 = i_s_axis_tdata[TW-1:0];
        if (n_t1 > T_ONE) begin
            n_t1 = T_ONE;
        end
        n_u1 = T_ONE - n_t1;
        n_u3 = {2'b00, n_u1} + {1'b0, n_u1, 1'b0};
    end

    // biased coordinates: k = 0 is x, 1 is y, 2 is z
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 4; i++) begin
                q[k][i] = r_pt[i][(2-k)*C +: C] ^ C_SIGN;
            end
        end
    end

    // sum of the pairs plus rounding half, then offset back to two's complement
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            tot[k] = r_s01[k] + r_s23[k] + HALF;
            n_out[k*C +: C] = tot[k][3*F +: C] ^ C_SIGN;
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            // stage 1
            r_t1 <= n_t1;
            r_u1 <= n_u1;
            r_u3 <= n_u3;
            // stage 2
            r_t2  <= r_t1;
            r_u2  <= r_u1;
            r_tt  <= W2'(r_t1) * W2'(r_t1);
            r_uu  <= W2'(r_u1) * W2'(r_u1);
            r_tu3 <= W2'(r_t1) * W2'(r_u3);
            // stage 3
            r_w[0] <= WW'(r_uu)  * WW'(r_u2);
            r_w[1] <= WW'(r_tu3) * WW'(r_u2);
            r_w[2] <= WW'(r_tu3) * WW'(r_t2);
            r_w[3] <= WW'(r_tt)  * WW'(r_t2);
            // stage 4
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 4; i++) begin
                    r_p[k][i] <= PW'(r_w[i]) * PW'(q[k][i]);
                end
            end
            // stage 5
            for (int k = 0; k < 3; k++) begin
                r_s01[k] <= r_p[k][0] + r_p[k][1];
                r_s23[k] <= r_p[k][2] + r_p[k][3];
            end
            // stage 6
            r_out <= n_out;
        end
    end

    // clamp keeps t at or below one
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_t1 <= T_ONE) && (r_t1 + r_u1 == T_ONE))
        else $error("clamped parameter out of range");

    // the four weights always add up to one
    a_weights: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_w[0] + r_w[1] + r_w[2] + r_w[3] == W_TOTAL))
        else $error("Bernstein weights do not sum to one");

    // an accepted word enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> r_vld[0])
        else $error("accepted word lost at pipeline entry");

endmodule
